@@ sv/svme_pkg.sv @@
// shared types, constants and command codes for the state vector measurement engine
package svme_pkg;

  localparam int unsigned MaxQubitsDefault = 10;
  localparam int unsigned AmpWidthDefault  = 16;
  localparam int unsigned CmdWidth         = 3;
  localparam int unsigned QubitWidth       = 4;
  localparam int unsigned ResultWidth      = 32;
  localparam int unsigned ProbWidth        = 30;
  localparam int unsigned StatusWidth      = 2;
  localparam int unsigned NumQubitsReset   = 10;
  localparam int unsigned MinProbReset     = 1;

  typedef enum logic [2:0] {
    CmdWrite   = 3'd0,
    CmdRead    = 3'd1,
    CmdProb    = 3'd2,
    CmdPauli   = 3'd3,
    CmdCollapse = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StQubit    = 2'd1,
    StPauli    = 2'd2,
    StZeroProb = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PauliX = 2'd0,
    PauliY = 2'd1,
    PauliZ = 2'd2,
    PauliBad = 2'd3
  } pauli_e;

  typedef enum logic [0:0] {
    CfgNumQubits = 1'b0,
    CfgMinProb   = 1'b1
  } cfg_e;

  // operations the back end carries out
  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpWrite  = 3'd1,
    OpRead   = 3'd2,
    OpSum    = 3'd3,
    OpPair   = 3'd4,
    OpCollapse = 3'd5
  } op_e;

endpackage

@@ sv/svme_front.sv @@
// front end: accepts items, checks qubit and pauli kind, decodes the operation
module svme_front
  import svme_pkg::*;
#(
  parameter int unsigned MaxQubits = MaxQubitsDefault,
  parameter int unsigned AmpWidth  = AmpWidthDefault,
  parameter int unsigned IdxW      = MaxQubits,
  parameter int unsigned NW        = $clog2(MaxQubits + 1)
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CmdWidth-1:0]  command_i,
  input  logic [IdxW-1:0]      index_i,
  input  logic [AmpWidth-1:0]  amp_real_i,
  input  logic [AmpWidth-1:0]  amp_imag_i,
  input  logic [QubitWidth-1:0] qubit_i,
  input  logic [1:0]           pauli_kind_i,
  input  logic                 target_value_i,
  input  logic [NW-1:0]        n_i,
  // queue write side
  output logic                 q_valid_o,
  input  logic                 q_full_i,
  output logic [2:0]           q_op_o,
  output logic [1:0]           q_status_o,
  output logic [IdxW-1:0]      q_bit_o,
  output logic [IdxW-1:0]      q_index_o,
  output logic [AmpWidth-1:0]  q_re_o,
  output logic [AmpWidth-1:0]  q_im_o,
  output logic [1:0]           q_kind_o,
  output logic                 q_target_o
);
  logic [NW-1:0] pos;
  logic          q_ok;

  assign in_stall_o = q_full_i;
  assign q_valid_o  = in_valid_i && !q_full_i;
  assign q_ok       = {{(32-QubitWidth){1'b0}}, qubit_i} < {{(32-NW){1'b0}}, n_i};
  assign pos        = NW'(n_i - NW'(1) - NW'(qubit_i));

  always_comb begin
    q_op_o     = OpNone;
    q_status_o = StOk;
    q_bit_o    = IdxW'(1) << pos;
    q_index_o  = index_i;
    q_re_o     = amp_real_i;
    q_im_o     = amp_imag_i;
    q_kind_o   = pauli_kind_i;
    q_target_o = target_value_i;
    case (command_i)
      CmdWrite: q_op_o = OpWrite;
      CmdRead:  q_op_o = OpRead;
      CmdProb, CmdPauli, CmdCollapse: begin
        if (!q_ok) begin
          q_status_o = StQubit;
        end else if (command_i == CmdProb) begin
          q_op_o   = OpSum;
          q_kind_o = PauliBad;   // plain sum of bit-0 entries
          q_target_o = 1'b0;
        end else if (command_i == CmdCollapse) begin
          q_op_o = OpCollapse;
        end else begin
          case (pauli_kind_i)
            PauliZ:  q_op_o = OpSum;
            PauliBad: q_status_o = StPauli;
            default: q_op_o = OpPair;
          endcase
        end
      end
      default: q_op_o = OpNone;
    endcase
  end
endmodule

@@ sv/svme_queue.sv @@
// two-entry queue between the front and back ends
module svme_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];
  assign cnt_d   = cnt_q + {1'b0, wr_i} - {1'b0, rd_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end
endmodule

@@ sv/svme_sqrt.sv @@
// bit-serial integer square root used by collapse
module svme_sqrt
  import svme_pkg::*;
#(
  parameter int unsigned InW = 48,
  parameter int unsigned RW  = InW / 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [InW-1:0] x_i,
  output logic           done_o,
  output logic [RW-1:0]  r_o
);
  localparam int unsigned CW = $clog2(RW + 1);
  logic [InW-1:0] x_q;
  logic [RW+1:0]  rem_q;
  logic [RW-1:0]  r_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [RW+1:0]  rem_sh, trial;

  assign rem_sh = {rem_q[RW-1:0], x_q[InW-1 -: 2]};
  assign trial  = {r_q, 2'b01};
  assign r_o    = r_q;
  assign done_o = busy_q && cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      rem_q <= '0;
      r_q   <= '0;
    end else if (busy_q && cnt_q != '0) begin
      x_q <= x_q << 2;
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        r_q   <= {r_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        r_q   <= {r_q[RW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ sv/svme_back.sv @@
// back end: amplitude memory, accumulating sweep, collapse scaling and result register
module svme_back
  import svme_pkg::*;
#(
  parameter int unsigned MaxQubits = MaxQubitsDefault,
  parameter int unsigned AmpWidth  = AmpWidthDefault,
  parameter int unsigned IdxW      = MaxQubits,
  parameter int unsigned NW        = $clog2(MaxQubits + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  output logic                   q_rd_o,
  input  logic [2:0]             op_i,
  input  logic [1:0]             status_i,
  input  logic [IdxW-1:0]        bit_i,
  input  logic [IdxW-1:0]        index_i,
  input  logic [AmpWidth-1:0]    re_i,
  input  logic [AmpWidth-1:0]    im_i,
  input  logic [1:0]             kind_i,
  input  logic                   target_i,
  input  logic [NW-1:0]          n_i,
  input  logic [ProbWidth-1:0]   min_prob_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ResultWidth-1:0] result_value_o,
  output logic [AmpWidth-1:0]    out_real_o,
  output logic [AmpWidth-1:0]    out_imag_o,
  output logic [StatusWidth-1:0] status_o
);
  localparam int unsigned Depth = 1 << MaxQubits;
  localparam int unsigned PW    = 2 * AmpWidth;         // one product
  localparam int unsigned AccW  = PW + MaxQubits + 3;   // exact sum
  localparam int unsigned SqW   = 2 * ((AccW + 16 + 1) / 2);
  localparam int unsigned RW    = SqW / 2;
  localparam int unsigned NumW  = AmpWidth + 23;
  localparam int unsigned DCW   = $clog2(NumW + 2);
  localparam logic signed [AccW-1:0] Max32 = AccW'(64'sh7fffffff);
  localparam logic signed [AccW-1:0] Min32 = -AccW'(64'sh80000000);

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SRead  = 10'b0000000010,
    SSweep = 10'b0000000100,
    SMul   = 10'b0000001000,
    SAdd   = 10'b0000010000,
    SRoot  = 10'b0000100000,
    SScRd  = 10'b0001000000,
    SDiv   = 10'b0010000000,
    SScWr  = 10'b0100000000,
    SOut   = 10'b1000000000
  } state_e;

  state_e state_q;
  logic [AmpWidth-1:0] mem_re [Depth];
  logic [AmpWidth-1:0] mem_im [Depth];
  logic [AmpWidth-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
  logic [IdxW:0]       cnt_q;
  logic [IdxW-1:0]     ra_q, rb_q;
  logic                rsel_q;        // 1: second read of a pair
  logic [2:0]          op_q;
  logic [1:0]          kind_q;
  logic                tgt_q;
  logic [IdxW-1:0]     bit_q, idx_q;
  logic signed [PW-1:0] p0_q, p1_q;
  logic                neg_q;
  logic signed [AccW-1:0] acc_q;
  logic [ResultWidth-1:0] res_q;
  logic [AmpWidth-1:0]    ore_q, oim_q;
  logic [1:0]             st_q;
  logic                   ov_q;
  logic                   out_load;
  logic [IdxW:0]          dim;
  logic                   sq_start, sq_done;
  logic [RW-1:0]          root;
  logic [SqW-1:0]         sq_in;
  // divider
  logic                   part_q;     // 0 real, 1 imag
  logic [NumW-1:0]        dnum_q;
  logic [NumW:0]          drem_q;
  logic [DCW-1:0]         dcnt_q;
  logic                   dneg_q;
  logic [AmpWidth-1:0]    sc_re_q;
  logic [NumW:0]          drem_sh;
  logic [AmpWidth-1:0]    mag_a, cur_a;
  logic signed [AmpWidth:0] sat_v;
  logic                   match;
  logic                   div_done;

  assign dim   = (IdxW+1)'(1) << n_i;
  assign sq_in = SqW'(acc_q) << 16;
  assign q_rd_o = state_q == SIdle && !q_empty_i;
  assign out_load = state_q == SOut && (!ov_q || !out_stall_i);
  // done once the numerator is loaded and all NumW quotient bits are produced
  assign div_done = dcnt_q == DCW'(NumW + 1);

  svme_sqrt #(.InW(SqW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(sq_in), .done_o(sq_done), .r_o(root)
  );
  assign sq_start = state_q == SAdd && op_q == OpCollapse && cnt_q == dim
                    && acc_q != '0 && acc_q >= AccW'(min_prob_i);

  function automatic logic [ResultWidth-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v > Max32) return ResultWidth'(Max32);
    if (v < Min32) return ResultWidth'(Min32);
    return v[ResultWidth-1:0];
  endfunction

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (state_q == SSweep || state_q == SScRd) begin
      if (rsel_q) begin
        b_re_q <= mem_re[rb_q];
        b_im_q <= mem_im[rb_q];
      end else begin
        a_re_q <= mem_re[ra_q];
        a_im_q <= mem_im[ra_q];
      end
    end else if (state_q == SRead) begin
      a_re_q <= mem_re[idx_q];
      a_im_q <= mem_im[idx_q];
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (q_rd_o && op_i == OpWrite) begin
      mem_re[index_i] <= re_i;
      mem_im[index_i] <= im_i;
    end else if (state_q == SScWr) begin
      mem_re[ra_q] <= match ? sc_re_q : '0;
      mem_im[ra_q] <= match ? sat_v[AmpWidth-1:0] : '0;
    end
  end

  assign match   = ((ra_q & bit_q) != '0) == tgt_q;
  assign drem_sh = {drem_q[NumW-1:0], dnum_q[NumW-1]};
  assign cur_a   = part_q ? a_im_q : a_re_q;
  assign mag_a   = cur_a[AmpWidth-1] ? AmpWidth'(-cur_a) : cur_a;
  // rounded quotient with sign, saturated
  always_comb begin
    logic [NumW-1:0] qv;
    qv = dnum_q;
    if (qv > NumW'((1 << (AmpWidth-1)) - 1) + NumW'(dneg_q))
      sat_v = dneg_q ? (AmpWidth+1)'(-(1 << (AmpWidth-1)))
                     : (AmpWidth+1)'((1 << (AmpWidth-1)) - 1);
    else
      sat_v = dneg_q ? -(AmpWidth+1)'(qv) : (AmpWidth+1)'(qv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      rsel_q  <= 1'b0;
    end else begin
      if (out_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (state_q)
        SIdle: if (!q_empty_i) begin
          op_q <= op_i; kind_q <= kind_i; tgt_q <= target_i; bit_q <= bit_i;
          idx_q <= index_i; st_q <= status_i;
          acc_q <= '0; res_q <= '0; ore_q <= '0; oim_q <= '0;
          cnt_q <= '0; ra_q <= '0; rsel_q <= 1'b0;
          case (op_i)
            OpRead: state_q <= SRead;
            OpSum, OpPair, OpCollapse: state_q <= SSweep;
            default: state_q <= SOut;
          endcase
        end
        SRead: state_q <= SMul;
        SSweep: begin
          // issue read of entry i (and of its partner for pair ops)
          if (op_q == OpPair && !rsel_q) begin
            rb_q   <= ra_q | bit_q;
            rsel_q <= 1'b1;
          end else begin
            rsel_q  <= 1'b0;
            state_q <= SMul;
          end
        end
        SMul: begin
          if (op_q == OpPair && kind_q == PauliY) begin
            p0_q <= $signed(a_re_q) * $signed(b_im_q);
            p1_q <= -($signed(a_im_q) * $signed(b_re_q));
          end else if (op_q == OpPair) begin
            p0_q <= $signed(a_re_q) * $signed(b_re_q);
            p1_q <= $signed(a_im_q) * $signed(b_im_q);
          end else begin
            p0_q <= $signed(a_re_q) * $signed(a_re_q);
            p1_q <= $signed(a_im_q) * $signed(a_im_q);
          end
          if (op_q == OpSum && kind_q == PauliZ) neg_q <= (ra_q & bit_q) != '0;
          else if (op_q == OpCollapse) neg_q <= ((ra_q & bit_q) != '0) != tgt_q;
          else neg_q <= (ra_q & bit_q) != '0;
          state_q <= SAdd;
        end
        SAdd: begin
          if (op_q == OpRead) begin
            ore_q <= a_re_q; oim_q <= a_im_q;
            res_q <= sat32(AccW'(p0_q) + AccW'(p1_q));
            state_q <= SOut;
          end else if (cnt_q != dim) begin
            if (op_q == OpSum && kind_q == PauliZ)
              acc_q <= neg_q ? acc_q - AccW'(p0_q) - AccW'(p1_q)
                             : acc_q + AccW'(p0_q) + AccW'(p1_q);
            else if (!neg_q)
              acc_q <= acc_q + AccW'(p0_q) + AccW'(p1_q);
            cnt_q <= cnt_q + (IdxW+1)'(1);
            ra_q  <= ra_q + IdxW'(1);
            if (cnt_q + (IdxW+1)'(1) != dim) state_q <= SSweep;
          end else begin
            if (op_q == OpPair) res_q <= sat32(acc_q <<< 1);
            else res_q <= sat32(acc_q);
            if (op_q == OpCollapse) begin
              if (sq_start) begin
                state_q <= SRoot;
              end else begin
                st_q <= StZeroProb;
                state_q <= SOut;
              end
            end else begin
              state_q <= SOut;
            end
          end
        end
        SRoot: if (sq_done) begin
          cnt_q <= '0; ra_q <= '0; part_q <= 1'b0;
          state_q <= SScRd;
        end
        SScRd: begin
          part_q <= 1'b0;
          state_q <= SDiv;
        end
        SDiv: begin
          if (div_done) begin
            if (!part_q) begin
              sc_re_q <= sat_v[AmpWidth-1:0];
              part_q  <= 1'b1;
            end else begin
              state_q <= SScWr;
            end
          end
        end
        SScWr: begin
          cnt_q <= cnt_q + (IdxW+1)'(1);
          ra_q  <= ra_q + IdxW'(1);
          state_q <= (cnt_q + (IdxW+1)'(1) == dim) ? SOut : SScRd;
        end
        SOut: if (out_load) begin
          result_value_o <= res_q;
          out_real_o <= ore_q;
          out_imag_o <= oim_q;
          status_o <= st_q;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // restoring division: (|a| << 23 + r/2) / r, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == SScRd) begin
      dcnt_q <= '0;
    end else if (state_q == SDiv) begin
      if (dcnt_q == '0) begin
        dnum_q <= (NumW'(mag_a) << 23) + NumW'(root >> 1);
        drem_q <= '0;
        dneg_q <= cur_a[AmpWidth-1];
        dcnt_q <= DCW'(1);
      end else if (!div_done) begin
        dcnt_q <= dcnt_q + DCW'(1);
        if (drem_sh >= (NumW+1)'(root)) begin
          drem_q <= drem_sh - (NumW+1)'(root);
          dnum_q <= {dnum_q[NumW-2:0], 1'b1};
        end else begin
          drem_q <= drem_sh;
          dnum_q <= {dnum_q[NumW-2:0], 1'b0};
        end
      end else if (!part_q) begin
        // real part done, restart for the imaginary part
        dcnt_q <= '0;
      end
    end
  end

  assign out_valid_o = ov_q;
endmodule

@@ sv/state_vector_measurement_engine.sv @@
// top level of the state vector measurement engine
// Holds 2^n Q1.15 complex amplitudes in an on-chip memory and runs one command
// per item: write, read with squared magnitude, probability of zero, Pauli
// X/Y/Z expectation, collapse. Probability, Z and collapse sums read each
// amplitude once and X and Y read each amplitude with its partner, all through
// the single memory read port. Collapse adds a bit-serial square root and then,
// per amplitude, a read step, two serial divisions (real and imaginary part)
// and a write step. A two-item queue lets the front end take items while the
// back end is busy; the result register frees the back end.
module state_vector_measurement_engine
  import svme_pkg::*;
#(
  parameter int unsigned MaxQubits = MaxQubitsDefault,
  parameter int unsigned AmpWidth  = AmpWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CmdWidth-1:0]    command_i,
  input  logic [MaxQubits-1:0]   index_i,
  input  logic [AmpWidth-1:0]    amp_real_i,
  input  logic [AmpWidth-1:0]    amp_imag_i,
  input  logic [QubitWidth-1:0]  qubit_i,
  input  logic [1:0]             pauli_kind_i,
  input  logic                   target_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ResultWidth-1:0] result_value_o,
  output logic [AmpWidth-1:0]    out_real_o,
  output logic [AmpWidth-1:0]    out_imag_o,
  output logic [StatusWidth-1:0] status_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [ProbWidth-1:0]   cfg_data_i
);
  localparam int unsigned IdxW = MaxQubits;
  localparam int unsigned NW   = $clog2(MaxQubits + 1);
  localparam int unsigned QW   = 3 + 2 + 2 * IdxW + 2 * AmpWidth + 2 + 1;

  logic [3:0]           nq_q;
  logic [ProbWidth-1:0] minp_q;
  logic [NW-1:0]        n_eff;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q   <= 4'(NumQubitsReset);
      minp_q <= ProbWidth'(MinProbReset);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgNumQubits: nq_q <= cfg_data_i[3:0];
        CfgMinProb:   minp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp qubit count into 1..MaxQubits
  always_comb begin
    if (nq_q == '0) n_eff = NW'(1);
    else if ({28'd0, nq_q} > MaxQubits) n_eff = NW'(MaxQubits);
    else n_eff = NW'(nq_q);
  end

  logic q_wr, q_full, q_rd, q_empty;
  logic [2:0] f_op, b_op;
  logic [1:0] f_st, f_kind, b_st, b_kind;
  logic [IdxW-1:0] f_bit, f_idx, b_bit, b_idx;
  logic [AmpWidth-1:0] f_re, f_im, b_re, b_im;
  logic f_tgt, b_tgt;

  svme_front #(.MaxQubits(MaxQubits), .AmpWidth(AmpWidth)) u_front (
    .in_valid_i, .in_stall_o, .command_i, .index_i,
    .amp_real_i, .amp_imag_i, .qubit_i, .pauli_kind_i, .target_value_i,
    .n_i(n_eff), .q_valid_o(q_wr), .q_full_i(q_full), .q_op_o(f_op),
    .q_status_o(f_st), .q_bit_o(f_bit), .q_index_o(f_idx), .q_re_o(f_re),
    .q_im_o(f_im), .q_kind_o(f_kind), .q_target_o(f_tgt)
  );

  svme_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .wr_i(q_wr),
    .wdata_i({f_op, f_st, f_bit, f_idx, f_re, f_im, f_kind, f_tgt}),
    .full_o(q_full), .rd_i(q_rd), .empty_o(q_empty),
    .rdata_o({b_op, b_st, b_bit, b_idx, b_re, b_im, b_kind, b_tgt})
  );

  svme_back #(.MaxQubits(MaxQubits), .AmpWidth(AmpWidth)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_rd_o(q_rd), .op_i(b_op),
    .status_i(b_st), .bit_i(b_bit), .index_i(b_idx), .re_i(b_re), .im_i(b_im),
    .kind_i(b_kind), .target_i(b_tgt), .n_i(n_eff), .min_prob_i(minp_q),
    .out_valid_o, .out_stall_i, .result_value_o, .out_real_o, .out_imag_o,
    .status_o
  );

  // a full queue must stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> in_stall_o)
    else $error("queue full without stall");
  // reads never happen from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_rd |-> !q_empty)
    else $error("queue read while empty");
  // a held result keeps its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o))
    else $error("status changed under stall");
endmodule
